@@ hw/rtl/rhc_pkg.sv @@
// shared types, constants and arithmetic helpers of the rgb/hsl color converter
`default_nettype none

package rhc_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int FRAC_BITS    = 16;
   localparam int DIV_W        = 12;
   localparam int DIV_STAGES   = 8;
   localparam int BACK_STAGES  = 7;

   localparam logic [1:0] OP_TO_HSL = 2'd0;
   localparam logic [1:0] OP_TO_RGB = 2'd1;
   localparam logic [1:0] OP_SCALE  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [17:0] T_HALF_TURN  = 18'd32768;
   localparam logic [17:0] T_ONE_HALF   = 18'd98304;
   localparam logic [17:0] T_TWO_TURN   = 18'd131072;
   localparam logic [17:0] T_THREE_TURN = 18'd196608;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [15:0]        hue;
      logic [15:0]        saturation;
      logic [15:0]        lightness;
      logic signed [15:0] dim_factor;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [15:0] out_hue;
      logic [15:0] out_saturation;
      logic [15:0] out_lightness;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [15:0]        hue;
      logic [15:0]        saturation;
      logic [15:0]        lightness;
      logic signed [15:0] dim_factor;
      logic [15:0]        light_calc;
      logic               d_zero;
   } carry_type;

   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rem;
      logic [15:0]      low;
      logic [15:0]      quo;
   } lane_type;

   typedef struct packed {
      carry_type carry;
      lane_type  lane_s;
      lane_type  lane_h;
   } div_type;

   function automatic lane_type div_step(input lane_type x);
      lane_type       y;
      logic [DIV_W:0] t;
      y = x;
      t = {x.rem, x.low[15]};
      y.low = {x.low[14:0], 1'b0};
      if (t >= {1'b0, x.divisor}) begin
         y.rem = DIV_W'(t - {1'b0, x.divisor});
         y.quo = {x.quo[14:0], 1'b1};
      end else begin
         y.rem = t[DIV_W-1:0];
         y.quo = {x.quo[14:0], 1'b0};
      end
      return y;
   endfunction

   function automatic logic [16:0] chan_factor(input logic [17:0] t);
      logic [17:0] dd;
      logic [16:0] f;
      dd = T_TWO_TURN - t;
      priority if (t < T_HALF_TURN) begin
         f = {t[15:0], 1'b0};
      end else if (t < T_ONE_HALF) begin
         f = 17'd65536;
      end else if (t < T_TWO_TURN) begin
         f = {dd[15:0], 1'b0};
      end else begin
         f = '0;
      end
      return f;
   endfunction

   function automatic logic [7:0] div257(input logic [15:0] w);
      logic [7:0]  c0;
      logic [15:0] chk;
      c0  = w[15:8];
      chk = {c0, 8'd0} + 16'(c0);
      return (chk > w) ? c0 - 8'd1 : c0;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rgb_hsl_color_converter_core.sv @@
// top level of the rgb/hsl color converter
// an accepted req beat passes the front, divider and back stages in order to its rsp beat
// throughput: one beat per cycle unless rsp stalls; 16 stages with per-stage valid bits
// a stalled rsp holds only the stages behind it; empty stages keep taking req beats
// reset: synchronous, clears every stage valid bit; payload registers are not reset
`default_nettype none

module rgb_hsl_color_converter_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire rhc_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rhc_pkg::rsp_type     rsp_payload
);

   logic             front_ready, div_ready, back_ready;
   logic             front_valid, div_valid;
   rhc_pkg::div_type front_data, div_data;

   rhc_hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_payload),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_data  (front_data)
   );

   rhc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (back_ready),
      .out_data  (div_data)
   );

   rhc_rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (back_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_payload)
   );

   assign req_stall = !front_ready;

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled while rsp side is free");

   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out_hue != 16'd0 || rsp_payload.out_saturation != 16'd0)
      |-> rsp_payload.out_red == 8'd0 && rsp_payload.out_green == 8'd0 &&
          rsp_payload.out_blue == 8'd0)
      else $error("rgb and hsl result fields both set");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_saturation == 16'd0 |-> rsp_payload.out_hue == 16'd0)
      else $error("nonzero hue with zero saturation");

endmodule

`default_nettype wire

@@ hw/rtl/rhc_hsl_front.sv @@
// front stage: channel extremes, lightness and divider operand setup
`default_nettype none

module rhc_hsl_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rhc_pkg::req_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rhc_pkg::div_type     out_data
);

   logic [7:0]  r, g, b, mx, mn, d;
   logic [8:0]  sum, den;
   logic [16:0] light17;
   logic [23:0] sdiv;
   logic [11:0] d12, num, d6;
   rhc_pkg::div_type st_in, st_ff;
   logic        v_ff;

   always_comb begin
      r = in_data.red;
      g = in_data.green;
      b = in_data.blue;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = 9'(mx) + 9'(mn);
      d = mx - mn;
      light17 = {sum, 8'd0} + 17'(sum) + 17'd1;
      den = (sum > 9'd255) ? 9'd510 - sum : sum;
      sdiv = {d, 16'd0} - 24'(d) + 24'(den[8:1]);
      d12 = 12'(d);
      d6 = (d12 << 2) + (d12 << 1);
      priority if (mx == r) begin
         num = (g >= b) ? 12'(g) - 12'(b) : d6 - (12'(b) - 12'(g));
      end else if (mx == g) begin
         num = (d12 << 1) + 12'(b) - 12'(r);
      end else begin
         num = (d12 << 2) + 12'(r) - 12'(g);
      end
      st_in.carry.op         = in_data.op;
      st_in.carry.hue        = in_data.hue;
      st_in.carry.saturation = in_data.saturation;
      st_in.carry.lightness  = in_data.lightness;
      st_in.carry.dim_factor = in_data.dim_factor;
      st_in.carry.light_calc = light17[16:1];
      st_in.carry.d_zero     = (d == 8'd0);
      st_in.lane_s.divisor   = 12'(den[7:0]);
      st_in.lane_s.rem       = 12'(sdiv[23:16]);
      st_in.lane_s.low       = sdiv[15:0];
      st_in.lane_s.quo       = '0;
      st_in.lane_h.divisor   = d6;
      st_in.lane_h.rem       = num;
      st_in.lane_h.low       = 16'((d12 << 1) + d12);
      st_in.lane_h.quo       = '0;
   end

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rhc_div_pipe.sv @@
// pipelined restoring dividers for saturation and hue, two quotient bits per stage
`default_nettype none

module rhc_div_pipe (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rhc_pkg::div_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rhc_pkg::div_type     out_data
);

   localparam int N = rhc_pkg::DIV_STAGES;

   rhc_pkg::div_type st_ff [N];
   rhc_pkg::div_type st_in [N];
   rhc_pkg::div_type src   [N];
   logic [N-1:0]     v_ff, rdy, up_valid;

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign src[k]      = in_data;
            assign up_valid[k] = in_valid;
         end else begin : g_next
            assign src[k]      = st_ff[k-1];
            assign up_valid[k] = v_ff[k-1];
         end
         if (k == N - 1) begin : g_last
            assign rdy[k] = !v_ff[k] || out_ready;
         end else begin : g_mid
            assign rdy[k] = !v_ff[k] || rdy[k+1];
         end

         always_comb begin
            st_in[k] = src[k];
            st_in[k].lane_s = rhc_pkg::div_step(rhc_pkg::div_step(src[k].lane_s));
            st_in[k].lane_h = rhc_pkg::div_step(rhc_pkg::div_step(src[k].lane_h));
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= up_valid[k];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               st_ff[k] <= st_in[k];
            end
         end
      end
   endgenerate

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[N-1];
   assign out_data  = st_ff[N-1];

endmodule

`default_nettype wire

@@ hw/rtl/rhc_rgb_back.sv @@
// back end: lightness scaling, hsl to rgb pipeline and result formatting
`default_nettype none

module rhc_rgb_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rhc_pkg::div_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rhc_pkg::rsp_type     out_data
);

   localparam int N = rhc_pkg::BACK_STAGES;

   logic [N-1:0] v_ff, rdy;

   // stage 1
   logic [15:0] hue_c, sat_c;
   logic [1:0]  op1_ff;
   logic [15:0] h1_ff, s1_ff, l1_ff, hh1_ff, hs1_ff, hl1_ff;
   logic        neg1_ff;
   logic [30:0] prod1_ff;
   logic [15:0] h1_in, s1_in, l1_in;
   // stage 2
   logic [1:0]         op2_ff;
   logic [15:0]        s2_ff, l2_ff, hh2_ff, hs2_ff, hl2_ff, l2_in;
   logic [17:0]        h3, tr2_ff, tg2_ff;
   logic signed [18:0] tb2_ff;
   // stage 3
   logic [1:0]  op3_ff;
   logic [15:0] s3_ff, l3_ff, hh3_ff, hs3_ff, hl3_ff;
   logic [31:0] ls3_ff;
   logic        low3_ff;
   logic [17:0] tr3_ff, tg3_ff, tb3_ff, tr3_in, tb3_in;
   logic signed [18:0] tb_w;
   // stage 4
   logic [1:0]  op4_ff;
   logic [15:0] q4_ff, l4_ff, hh4_ff, hs4_ff, hl4_ff;
   logic [17:0] tr4_ff, tg4_ff, tb4_ff;
   logic [16:0] y, kk, fl, rm, ce, q4_in;
   // stage 5
   logic [1:0]  op5_ff;
   logic [15:0] p5_ff, qp5_ff, hh5_ff, hs5_ff, hl5_ff;
   logic [16:0] mr5_ff, mg5_ff, mb5_ff, p_w;
   // stage 6
   logic [1:0]  op6_ff;
   logic [15:0] p6_ff, hh6_ff, hs6_ff, hl6_ff;
   logic [32:0] pr6_ff, pg6_ff, pb6_ff;
   // stage 7
   rhc_pkg::rsp_type res_ff, res_in;
   logic [16:0] wr, wg, wb;

   always_comb begin
      rdy[N-1] = !v_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < N; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      hue_c = in_data.carry.d_zero ? 16'd0 : in_data.lane_h.quo;
      sat_c = in_data.carry.d_zero ? 16'd0 : in_data.lane_s.quo;
      if (in_data.carry.op == rhc_pkg::OP_TO_RGB) begin
         h1_in = in_data.carry.hue;
         s1_in = in_data.carry.saturation;
         l1_in = in_data.carry.lightness;
      end else begin
         h1_in = hue_c;
         s1_in = sat_c;
         l1_in = in_data.carry.light_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         op1_ff   <= in_data.carry.op;
         h1_ff    <= h1_in;
         s1_ff    <= s1_in;
         l1_ff    <= l1_in;
         hh1_ff   <= hue_c;
         hs1_ff   <= sat_c;
         hl1_ff   <= in_data.carry.light_calc;
         neg1_ff  <= in_data.carry.dim_factor[15];
         prod1_ff <= 31'(in_data.carry.light_calc) * 31'(in_data.carry.dim_factor[14:0]);
      end
   end

   always_comb begin
      if (op1_ff == rhc_pkg::OP_SCALE && !neg1_ff) begin
         l2_in = prod1_ff[30] ? 16'hFFFF : prod1_ff[29:14];
      end else begin
         l2_in = l1_ff;
      end
      h3 = ({2'b00, h1_ff} << 1) + {2'b00, h1_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         op2_ff <= op1_ff;
         s2_ff  <= s1_ff;
         l2_ff  <= l2_in;
         hh2_ff <= hh1_ff;
         hs2_ff <= hs1_ff;
         hl2_ff <= hl1_ff;
         tr2_ff <= h3 + 18'd65536;
         tg2_ff <= h3;
         tb2_ff <= signed'({1'b0, h3}) - 19'sd65536;
      end
   end

   always_comb begin
      tr3_in = (tr2_ff > rhc_pkg::T_THREE_TURN) ? tr2_ff - rhc_pkg::T_THREE_TURN : tr2_ff;
      tb_w   = (tb2_ff < 19'sd0) ? tb2_ff + 19'sd196608 : tb2_ff;
      tb3_in = tb_w[17:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         op3_ff  <= op2_ff;
         s3_ff   <= s2_ff;
         l3_ff   <= l2_ff;
         ls3_ff  <= 32'(l2_ff) * 32'(s2_ff);
         low3_ff <= !l2_ff[15];
         tr3_ff  <= tr3_in;
         tg3_ff  <= tg2_ff;
         tb3_ff  <= tb3_in;
         hh3_ff  <= hh2_ff;
         hs3_ff  <= hs2_ff;
         hl3_ff  <= hl2_ff;
      end
   end

   // ls / 65535 as high half plus low half, then at most two corrections
   always_comb begin
      y = 17'(ls3_ff[31:16]) + 17'(ls3_ff[15:0]);
      priority if (y >= 17'd131070) begin
         kk = 17'd2;
         rm = y - 17'd131070;
      end else if (y >= 17'd65535) begin
         kk = 17'd1;
         rm = y - 17'd65535;
      end else begin
         kk = 17'd0;
         rm = y;
      end
      fl = 17'(ls3_ff[31:16]) + kk;
      ce = fl + ((rm != 17'd0) ? 17'd1 : 17'd0);
      q4_in = low3_ff ? 17'(l3_ff) + fl : 17'(l3_ff) + 17'(s3_ff) - ce;
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         op4_ff <= op3_ff;
         q4_ff  <= q4_in[15:0];
         l4_ff  <= l3_ff;
         tr4_ff <= tr3_ff;
         tg4_ff <= tg3_ff;
         tb4_ff <= tb3_ff;
         hh4_ff <= hh3_ff;
         hs4_ff <= hs3_ff;
         hl4_ff <= hl3_ff;
      end
   end

   assign p_w = {l4_ff, 1'b0} - 17'(q4_ff);

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         op5_ff <= op4_ff;
         p5_ff  <= p_w[15:0];
         qp5_ff <= q4_ff - p_w[15:0];
         mr5_ff <= rhc_pkg::chan_factor(tr4_ff);
         mg5_ff <= rhc_pkg::chan_factor(tg4_ff);
         mb5_ff <= rhc_pkg::chan_factor(tb4_ff);
         hh5_ff <= hh4_ff;
         hs5_ff <= hs4_ff;
         hl5_ff <= hl4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         op6_ff <= op5_ff;
         p6_ff  <= p5_ff;
         pr6_ff <= 33'(qp5_ff) * 33'(mr5_ff);
         pg6_ff <= 33'(qp5_ff) * 33'(mg5_ff);
         pb6_ff <= 33'(qp5_ff) * 33'(mb5_ff);
         hh6_ff <= hh5_ff;
         hs6_ff <= hs5_ff;
         hl6_ff <= hl5_ff;
      end
   end

   always_comb begin
      wr = 17'(p6_ff) + pr6_ff[32:16];
      wg = 17'(p6_ff) + pg6_ff[32:16];
      wb = 17'(p6_ff) + pb6_ff[32:16];
      res_in = '0;
      unique case (op6_ff)
         rhc_pkg::OP_TO_HSL: begin
            res_in.out_hue        = hh6_ff;
            res_in.out_saturation = hs6_ff;
            res_in.out_lightness  = hl6_ff;
         end
         rhc_pkg::OP_TO_RGB, rhc_pkg::OP_SCALE: begin
            res_in.out_red   = rhc_pkg::div257(wr[15:0]);
            res_in.out_green = rhc_pkg::div257(wg[15:0]);
            res_in.out_blue  = rhc_pkg::div257(wb[15:0]);
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[N-1];
   assign out_data  = res_ff;

endmodule

`default_nettype wire
